@@ hdl/bfm_pkg.sv @@
// Shared types and constants for the Bloom filter with a 128-bit key hash.
// Used by the hash engine, the probe unit and the top level.
package bfm_pkg;

  localparam int unsigned FilterBitsDef = 65536;

  // Hash constants.
  localparam logic [63:0] MixC1 = 64'h87c37b91114253d5;
  localparam logic [63:0] MixC2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] MixN1 = 64'h0000000052dce729;
  localparam logic [63:0] MixN2 = 64'h0000000038495ab5;
  localparam logic [63:0] FinC1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FinC2 = 64'hc4ceb9fe1a85ec53;

  localparam logic [5:0] MaxProbes = 6'd32;

  // Register indexes of the configuration port.
  localparam logic [1:0] RegNumBits   = 2'd0;
  localparam logic [1:0] RegNumHashes = 2'd1;

  // Operation codes.
  localparam logic FuncAdd   = 1'b0;
  localparam logic FuncQuery = 1'b1;

  // Finished key hash handed to the probe unit.
  typedef struct packed {
    logic        func;
    logic [63:0] h1;
    logic [63:0] h2;
  } probe_req_t;

  // Status of the probe unit seen by the hash engine and the top level.
  typedef struct packed {
    logic ready;
    logic clearing;
  } probe_stat_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    rotl64 = (x << r) | (x >> (64 - r));
  endfunction

endpackage

@@ hdl/bfm_if.sv @@
// Channel interfaces: key chunks in, results out.
// Depends on nothing but the valid/ready handshake convention.
interface bfm_chunk_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [63:0] key_low_word;
  logic [63:0] key_high_word;
  logic [4:0]  valid_bytes;
  logic        last_chunk;

  modport source (output valid, func, key_low_word, key_high_word, valid_bytes,
                  last_chunk, input ready);
  modport sink (input valid, func, key_low_word, key_high_word, valid_bytes,
                last_chunk, output ready);
endinterface

interface bfm_result_if;
  logic valid;
  logic ready;
  logic was_add;
  logic is_present;

  modport source (output valid, was_add, is_present, input ready);
  modport sink (input valid, was_add, is_present, output ready);
endinterface

@@ hdl/bfm_hash.sv @@
// Key hash engine: mixes 16-byte chunks and finalizes the two 64-bit lanes.
// Uses bfm_pkg; one shared 32x32 multiplier does every 64-bit product.
module bfm_hash
  import bfm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [63:0] lo_i,
  input  logic [63:0] hi_i,
  input  logic [4:0]  nbytes_i,
  input  logic        last_i,
  input  probe_stat_t stat_i,
  output logic        req_valid_o,
  output probe_req_t  req_o
);

  localparam logic [4:0] StIdle = 5'd0;
  localparam logic [4:0] StK1A  = 5'd1;
  localparam logic [4:0] StK1B  = 5'd2;
  localparam logic [4:0] StK2A  = 5'd3;
  localparam logic [4:0] StK2B  = 5'd4;
  localparam logic [4:0] StT2A  = 5'd5;
  localparam logic [4:0] StT2B  = 5'd6;
  localparam logic [4:0] StT1A  = 5'd7;
  localparam logic [4:0] StT1B  = 5'd8;
  localparam logic [4:0] StFin0 = 5'd9;
  localparam logic [4:0] StFin1 = 5'd10;
  localparam logic [4:0] StFA   = 5'd11;
  localparam logic [4:0] StFB   = 5'd12;
  localparam logic [4:0] StGA   = 5'd13;
  localparam logic [4:0] StGB   = 5'd14;
  localparam logic [4:0] StFin2 = 5'd15;
  localparam logic [4:0] StFin3 = 5'd16;
  localparam logic [4:0] StHand = 5'd17;

  logic [4:0]  st_q, st_d;
  logic [1:0]  sc_q, sc_d;
  logic [63:0] h1_q, h1_d, h2_q, h2_d, w_q, w_d, acc_q, acc_d;
  logic [31:0] len_q, len_d;
  logic [63:0] lo_q, lo_d, hi_q, hi_d;
  logic        last_q, last_d, func_q, func_d;

  logic        is_mul;
  logic [63:0] mconst;
  logic [31:0] ma, mb;
  logic [63:0] prod, mres;
  logic        mul_done;
  logic [4:0]  n_in;
  logic [63:0] lo_m, hi_m, l64, t1, t2;

  // Valid count saturates at sixteen; bytes past it read as zero.
  always_comb begin
    n_in = (nbytes_i > 5'd16) ? 5'd16 : nbytes_i;
    for (int j = 0; j < 8; j++) begin
      lo_m[8*j +: 8] = (5'(j) < n_in) ? lo_i[8*j +: 8] : 8'h00;
      hi_m[8*j +: 8] = (5'(j + 8) < n_in) ? hi_i[8*j +: 8] : 8'h00;
    end
  end

  // Constant of the current multiply step.
  always_comb begin
    is_mul = 1'b1;
    case (st_q)
      StK1A, StT1A, StK2B, StT2B: mconst = MixC1;
      StK1B, StT1B, StK2A, StT2A: mconst = MixC2;
      StFA, StGA:                 mconst = FinC1;
      StFB, StGB:                 mconst = FinC2;
      default: begin
        mconst = 64'd0;
        is_mul = 1'b0;
      end
    endcase
  end

  // Low 64 bits of w * const from three partial products.
  assign ma       = (sc_q == 2'd2) ? w_q[63:32] : w_q[31:0];
  assign mb       = (sc_q == 2'd1) ? mconst[63:32] : mconst[31:0];
  assign prod     = ma * mb;
  assign mres     = acc_q + {prod[31:0], 32'd0};
  assign mul_done = is_mul && (sc_q == 2'd2);

  // Block mix of each lane from the finished key word product.
  assign l64 = {32'd0, len_q};
  assign t1  = rotl64(h1_q ^ mres, 27) + h2_q;
  assign t2  = rotl64(h2_q ^ mres, 31) + h1_q;

  always_comb begin
    st_d   = st_q;
    sc_d   = sc_q;
    h1_d   = h1_q;
    h2_d   = h2_q;
    w_d    = w_q;
    acc_d  = acc_q;
    len_d  = len_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    last_d = last_q;
    func_d = func_q;

    if (is_mul) begin
      sc_d  = (sc_q == 2'd2) ? 2'd0 : sc_q + 2'd1;
      acc_d = (sc_q == 2'd0) ? prod : mres;
      if (mul_done) w_d = mres;
    end

    unique case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          lo_d   = lo_m;
          hi_d   = hi_m;
          last_d = last_i;
          func_d = func_i;
          len_d  = len_q + {27'd0, n_in};
          if (!last_i || n_in == 5'd16) begin
            w_d  = lo_m;
            st_d = StK1A;
          end else if (n_in > 5'd8) begin
            w_d  = hi_m;
            st_d = StT2A;
          end else if (n_in != 5'd0) begin
            w_d  = lo_m;
            st_d = StT1A;
          end else begin
            st_d = StFin0;
          end
        end
      end
      StK1A: if (mul_done) begin
        w_d  = rotl64(mres, 31);
        st_d = StK1B;
      end
      StK1B: if (mul_done) begin
        h1_d = (t1 << 2) + t1 + MixN1;
        w_d  = hi_q;
        st_d = StK2A;
      end
      StK2A: if (mul_done) begin
        w_d  = rotl64(mres, 33);
        st_d = StK2B;
      end
      StK2B: if (mul_done) begin
        h2_d = (t2 << 2) + t2 + MixN2;
        st_d = last_q ? StFin0 : StIdle;
      end
      StT2A: if (mul_done) begin
        w_d  = rotl64(mres, 33);
        st_d = StT2B;
      end
      StT2B: if (mul_done) begin
        h2_d = h2_q ^ mres;
        w_d  = lo_q;
        st_d = StT1A;
      end
      StT1A: if (mul_done) begin
        w_d  = rotl64(mres, 31);
        st_d = StT1B;
      end
      StT1B: if (mul_done) begin
        h1_d = h1_q ^ mres;
        st_d = StFin0;
      end
      StFin0: begin
        h1_d = (h1_q ^ l64) + (h2_q ^ l64);
        h2_d = h2_q ^ l64;
        st_d = StFin1;
      end
      StFin1: begin
        h2_d = h2_q + h1_q;
        w_d  = h1_q ^ (h1_q >> 33);
        st_d = StFA;
      end
      StFA: if (mul_done) begin
        w_d  = mres ^ (mres >> 33);
        st_d = StFB;
      end
      StFB: if (mul_done) begin
        h1_d = mres ^ (mres >> 33);
        w_d  = h2_q ^ (h2_q >> 33);
        st_d = StGA;
      end
      StGA: if (mul_done) begin
        w_d  = mres ^ (mres >> 33);
        st_d = StGB;
      end
      StGB: if (mul_done) begin
        h2_d = mres ^ (mres >> 33);
        st_d = StFin2;
      end
      StFin2: begin
        h1_d = h1_q + h2_q;
        st_d = StFin3;
      end
      StFin3: begin
        h2_d = h2_q + h1_q;
        st_d = StHand;
      end
      StHand: begin
        // Lanes and length return to the seed once the probe unit takes the hash.
        if (stat_i.ready) begin
          h1_d  = 64'd0;
          h2_d  = 64'd0;
          len_d = 32'd0;
          st_d  = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  assign in_ready_o  = (st_q == StIdle) && !stat_i.clearing;
  assign req_valid_o = (st_q == StHand);
  assign req_o       = '{func: func_q, h1: h1_q, h2: h2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      sc_q  <= 2'd0;
      h1_q  <= 64'd0;
      h2_q  <= 64'd0;
      len_q <= 32'd0;
    end else begin
      st_q  <= in_ready_o || st_q != StIdle ? st_d : st_q;
      sc_q  <= sc_d;
      h1_q  <= h1_d;
      h2_q  <= h2_d;
      len_q <= in_ready_o || st_q != StIdle ? len_d : len_q;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= w_d;
    acc_q  <= acc_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    last_q <= last_d;
    func_q <= func_d;
  end

endmodule

@@ hdl/bfm_probe.sv @@
// Probe unit: reduces the key hash modulo the filter size, then walks the
// probe indices over the filter bit memory. Uses bfm_pkg.
module bfm_probe
  import bfm_pkg::*;
#(
  parameter int unsigned FILTER_BITS = FilterBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  input  probe_req_t                     req_i,
  input  logic [$clog2(FILTER_BITS):0]   modulus_i,
  input  logic [5:0]                     probes_i,
  output probe_stat_t                    stat_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_was_add_o,
  output logic                           out_present_o
);

  localparam int unsigned IdxW = $clog2(FILTER_BITS);
  localparam int unsigned MW   = IdxW + 1;

  localparam logic [2:0] StClr  = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StMod  = 3'd2;
  localparam logic [2:0] StStep = 3'd3;
  localparam logic [2:0] StChk  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic            mem_q [FILTER_BITS];
  logic            rdata_q;
  logic [2:0]      st_q;
  logic [MW-1:0]   clr_q;
  logic [5:0]      bit_q, cnt_q, nprb_q;
  logic [MW-1:0]   m_q, r1_q, r2_q, r3_q;
  logic [63:0]     h1_q, h2_q, x_q;
  logic            func_q, pres_q;
  logic            ov_q, oadd_q, opres_q;

  logic [MW-1:0]   t1, t2, t3, m1, m2, m3, rsum, radv, r3p, rwrap, radj;
  logic [64:0]     xsum;
  logic            mem_we, mem_wd, last_probe;
  logic [IdxW-1:0] mem_wa;

  // One restoring remainder step for each lane. The third lane reduces
  // 2^64 - 1, which gives the correction for a wrapped 64-bit sum.
  assign t1 = {r1_q[IdxW-1:0], h1_q[bit_q]};
  assign t2 = {r2_q[IdxW-1:0], h2_q[bit_q]};
  assign t3 = {r3_q[IdxW-1:0], 1'b1};
  assign m1 = (t1 >= m_q) ? t1 - m_q : t1;
  assign m2 = (t2 >= m_q) ? t2 - m_q : t2;
  assign m3 = (t3 >= m_q) ? t3 - m_q : t3;

  // 2^64 modulo the modulus.
  assign r3p   = r3_q + MW'(1);
  assign rwrap = (r3p == m_q) ? '0 : r3p;

  // Next probe index: the running 64-bit sum h1 + i*h2 wraps like the hash
  // arithmetic, so a carry out takes 2^64 mod the modulus off the remainder.
  assign xsum       = {1'b0, x_q} + {1'b0, h2_q};
  assign rsum       = r1_q + r2_q;
  assign radv       = (rsum >= m_q) ? rsum - m_q : rsum;
  assign radj       = !xsum[64] ? radv :
                      (radv >= rwrap) ? radv - rwrap : m_q - (rwrap - radv);
  assign last_probe = (cnt_q + 6'd1 == nprb_q);

  assign mem_we = (st_q == StClr) || (st_q == StStep && func_q == FuncAdd);
  assign mem_wd = (st_q != StClr);
  assign mem_wa = (st_q == StClr) ? clr_q[IdxW-1:0] : r1_q[IdxW-1:0];

  // Filter bit store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rdata_q <= mem_q[r1_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StClr;
      clr_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (ov_q && out_ready_i && st_q != StDone) ov_q <= 1'b0;
      unique case (st_q)
        StClr: begin
          clr_q <= clr_q + MW'(1);
          if (clr_q == MW'(FILTER_BITS - 1)) st_q <= StIdle;
        end
        StIdle: if (req_valid_i) st_q <= StMod;
        StMod: if (bit_q == 6'd0) st_q <= (nprb_q == 6'd0) ? StDone : StStep;
        StStep: begin
          if (func_q == FuncQuery) st_q <= StChk;
          else if (last_probe) st_q <= StDone;
        end
        StChk: st_q <= last_probe ? StDone : StStep;
        StDone: begin
          if (!ov_q || out_ready_i) begin
            ov_q <= 1'b1;
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        h1_q   <= req_i.h1;
        h2_q   <= req_i.h2;
        x_q    <= req_i.h1;
        func_q <= req_i.func;
        m_q    <= modulus_i;
        nprb_q <= (probes_i > MaxProbes) ? MaxProbes : probes_i;
        bit_q  <= 6'd63;
        r1_q   <= '0;
        r2_q   <= '0;
        r3_q   <= '0;
        cnt_q  <= 6'd0;
        pres_q <= 1'b1;
      end
      StMod: begin
        r1_q  <= m1;
        r2_q  <= m2;
        r3_q  <= m3;
        bit_q <= bit_q - 6'd1;
      end
      StStep: begin
        if (func_q == FuncAdd) begin
          r1_q  <= radj;
          x_q   <= xsum[63:0];
          cnt_q <= cnt_q + 6'd1;
        end
      end
      StChk: begin
        pres_q <= pres_q & rdata_q;
        r1_q   <= radj;
        x_q    <= xsum[63:0];
        cnt_q  <= cnt_q + 6'd1;
      end
      StDone: begin
        if (!ov_q || out_ready_i) begin
          oadd_q  <= (func_q == FuncAdd);
          opres_q <= (func_q == FuncQuery) && pres_q;
        end
      end
      default: ;
    endcase
  end

  assign stat_o        = '{ready: (st_q == StIdle), clearing: (st_q == StClr)};
  assign out_valid_o   = ov_q;
  assign out_was_add_o = oadd_q;
  assign out_present_o = opres_q;

endmodule

@@ hdl/bloom_filter_murmur3_double_hash.sv @@
// Bloom filter with a 128-bit MurmurHash3-style key hash and double hashing.
// Top level: configuration registers and channel wiring. Uses bfm_pkg,
// bfm_if, bfm_hash and bfm_probe.
//
// Keys arrive as 16-byte chunks; the last chunk yields one result. After reset
// the filter memory is cleared one bit per cycle, every bit of it, with chunk
// ready held low. A full chunk takes four 64-bit products in the hash engine
// on one shared 32x32 multiplier, each built from three partial products; a
// short last chunk takes up to four. Finalization adds four more products.
// The probe unit then reduces the hash modulo the modulus, one remainder bit
// per cycle, which also yields 2^64 mod the modulus for wrapped index sums,
// then walks the probes: an add writes each bit in a step state, a query
// reads it there and checks the registered read data in a check state, and
// a done state posts the result. The next key's chunks are hashed while the
// previous key probes, and a finished result waits in an output register.
module bloom_filter_murmur3_double_hash
  import bfm_pkg::*;
#(
  parameter int unsigned FILTER_BITS = FilterBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [16:0]  cfg_wdata_i,
  bfm_chunk_if.sink    chunk_i,
  bfm_result_if.source result_o
);

  localparam int unsigned MW = $clog2(FILTER_BITS) + 1;

  logic [16:0] num_bits_q;
  logic [5:0]  num_hashes_q;
  logic [31:0] mod_full;
  logic [MW-1:0] modulus;
  probe_stat_t stat;
  probe_req_t  req;
  logic        req_valid;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_bits_q   <= 17'd65536;
      num_hashes_q <= 6'd7;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegNumBits:   num_bits_q   <= cfg_wdata_i;
        RegNumHashes: num_hashes_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // Modulus clamped to one through the filter size.
  always_comb begin
    mod_full = {15'd0, num_bits_q};
    if (mod_full == 32'd0) mod_full = 32'd1;
    if (mod_full > 32'(FILTER_BITS)) mod_full = 32'(FILTER_BITS);
  end
  assign modulus = mod_full[MW-1:0];

  bfm_hash u_hash (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chunk_i.valid),
    .in_ready_o  (chunk_i.ready),
    .func_i      (chunk_i.func),
    .lo_i        (chunk_i.key_low_word),
    .hi_i        (chunk_i.key_high_word),
    .nbytes_i    (chunk_i.valid_bytes),
    .last_i      (chunk_i.last_chunk),
    .stat_i      (stat),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  bfm_probe #(.FILTER_BITS(FILTER_BITS)) u_probe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_valid),
    .req_i         (req),
    .modulus_i     (modulus),
    .probes_i      (num_hashes_q),
    .stat_o        (stat),
    .out_valid_o   (result_o.valid),
    .out_ready_i   (result_o.ready),
    .out_was_add_o (result_o.was_add),
    .out_present_o (result_o.is_present)
  );

  // No chunk transfer while the filter memory is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> !chunk_i.ready)
    else $error("chunk accepted during memory clear");

  // An add never reports a present answer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.was_add |-> !result_o.is_present)
    else $error("add reported present");

  // A finished hash offered while the probe unit is idle must be taken: the request then drops.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && stat.ready |=> !req_valid)
    else $error("hash handoff not taken");

endmodule
